// ===== rtl/msctg_pkg.sv =====
// ----------------------------------------------------------------------------
// msctg_pkg
// shared widths, constants and status types of the step/chirp test generator
// ----------------------------------------------------------------------------
package msctg_pkg;

  localparam int NUM_ACTUATORS = 8;

  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 14;
  localparam int HALF_W  = 21;
  localparam int QHZ_W   = 7;
  localparam int CNT_W   = $clog2(TIME_W);
  localparam int DIV_CNT_W = $clog2(HALF_W);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX       = LEVEL_W'(9600);
  localparam logic [HALF_W-1:0]  HALF_PERIOD_NUM = HALF_W'(2000000);

  typedef struct packed {
    logic done;
    logic gt;
  } cmp_status_t;

  typedef struct packed {
    logic              done;
    logic [HALF_W-1:0] quotient;
  } div_status_t;

endpackage

// ===== rtl/msctg_serial_cmp.sv =====
// ----------------------------------------------------------------------------
// msctg_serial_cmp
// bit-serial elapsed-time compare: flags (a - b) mod 2^32 > c, lsb first
// ----------------------------------------------------------------------------
module msctg_serial_cmp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [msctg_pkg::TIME_W-1:0]  a,
  input  logic [msctg_pkg::TIME_W-1:0]  b,
  input  logic [msctg_pkg::TIME_W-1:0]  c,
  output msctg_pkg::cmp_status_t        status
);

  logic [msctg_pkg::TIME_W-1:0] a_sr;
  logic [msctg_pkg::TIME_W-1:0] b_sr;
  logic [msctg_pkg::TIME_W-1:0] c_sr;
  logic [msctg_pkg::CNT_W-1:0]  cnt;
  logic                         busy;
  logic                         brw_d;
  logic                         brw_c;
  logic                         d_bit;
  logic                         brw_d_next;
  logic                         brw_c_next;

  // difference bit, then borrow of c minus difference
  always_comb begin
    d_bit      = a_sr[0] ^ b_sr[0] ^ brw_d;
    brw_d_next = (~a_sr[0] & b_sr[0]) | (~(a_sr[0] ^ b_sr[0]) & brw_d);
    brw_c_next = (~c_sr[0] & d_bit) | (~(c_sr[0] ^ d_bit) & brw_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cnt         <= '0;
      brw_d       <= 1'b0;
      brw_c       <= 1'b0;
      status.done <= 1'b0;
      status.gt   <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        a_sr  <= a;
        b_sr  <= b;
        c_sr  <= c;
        cnt   <= '0;
        brw_d <= 1'b0;
        brw_c <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        a_sr  <= a_sr >> 1;
        b_sr  <= b_sr >> 1;
        c_sr  <= c_sr >> 1;
        brw_d <= brw_d_next;
        brw_c <= brw_c_next;
        cnt   <= cnt + 1'b1;
        if (cnt == msctg_pkg::CNT_W'(msctg_pkg::TIME_W - 1)) begin
          busy        <= 1'b0;
          status.done <= 1'b1;
          status.gt   <= brw_c_next;
        end
      end
    end
  end

endmodule

// ===== rtl/msctg_serial_div.sv =====
// ----------------------------------------------------------------------------
// msctg_serial_div
// restoring divider, one quotient bit per cycle: half period from frequency
// ----------------------------------------------------------------------------
module msctg_serial_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [msctg_pkg::QHZ_W-1:0]  divisor,
  output msctg_pkg::div_status_t       status
);

  logic [msctg_pkg::HALF_W-1:0]    dvd_sr;
  logic [msctg_pkg::HALF_W-1:0]    quo;
  logic [msctg_pkg::QHZ_W:0]       rem;
  logic [msctg_pkg::QHZ_W-1:0]     dsr;
  logic [msctg_pkg::DIV_CNT_W-1:0] cnt;
  logic                            busy;
  logic [msctg_pkg::QHZ_W:0]       trial;
  logic                            q_bit;

  always_comb begin
    trial = {rem[msctg_pkg::QHZ_W-1:0], dvd_sr[msctg_pkg::HALF_W-1]};
    q_bit = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cnt         <= '0;
      status.done <= 1'b0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        dvd_sr <= msctg_pkg::HALF_PERIOD_NUM;
        dsr    <= divisor;
        rem    <= '0;
        quo    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        dvd_sr <= dvd_sr << 1;
        rem    <= q_bit ? (trial - {1'b0, dsr}) : trial;
        quo    <= {quo[msctg_pkg::HALF_W-2:0], q_bit};
        cnt    <= cnt + 1'b1;
        if (cnt == msctg_pkg::DIV_CNT_W'(msctg_pkg::HALF_W - 1)) begin
          busy        <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  // zero frequency falls back to the base half period
  assign status.quotient = (dsr == '0) ? msctg_pkg::HALF_PERIOD_NUM : quo;

endmodule

// ===== rtl/motor_step_chirp_test_generator_top.sv =====
// ----------------------------------------------------------------------------
// motor_step_chirp_test_generator_top
// step / chirp drive-level test generator for one motor
// ----------------------------------------------------------------------------
// input stream: s_tuser carries the command (tick, start, stop), s_tdata the
//   32-bit microsecond timestamp. one result transaction per input transaction
//   on the output stream: m_tuser flags an issued drive command, m_tdata holds
//   target actuator, drive level and running status.
// configuration: cfg_wr_en/cfg_index/cfg_data write one register per cycle;
//   level, actuator and mode writes are dropped while a test runs.
// sequence: start, stop and idle ticks go straight to the output register;
//   a tick of a running test first runs the bit-serial compares of elapsed
//   time, then the serial half-period divider when a chirp frequency step
//   needs a new half period. one transaction is in flight at a time, so a new
//   input is taken only once the previous one has reached the output register.
// reset: rst (synchronous) restores the configuration and test registers to
//   their defaults, stops any test and empties the output register.
// stall: s_tready stays high while idle even with a result waiting; a held
//   m_tready makes the next transaction wait in the output stage until the
//   previous result is taken.
// ----------------------------------------------------------------------------
module motor_step_chirp_test_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // now_us[31:0]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // target_actuator[2:0], drive_level[16:3],
                                 // test_running[17], zero[23:18]
  output logic        m_tuser,   // drive_valid[0]
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_DIV, S_OUT} state_t;
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;
  typedef enum logic [2:0] {
    REG_LEVEL_LOW, REG_LEVEL_HIGH, REG_ACT_SEL, REG_TEST_MODE,
    REG_STEP_PERIOD, REG_SWAP_LIMIT, REG_CHIRP_DWELL, REG_CHIRP_LIMIT
  } reg_idx_t;

  localparam logic [3:0] SEL_NONE = 4'hF;

  state_t state;

  // configuration registers
  logic [msctg_pkg::LEVEL_W-1:0] level_low;
  logic [msctg_pkg::LEVEL_W-1:0] level_high;
  logic [3:0]                    act_sel;
  logic                          test_mode;
  logic [23:0]                   step_period;
  logic [7:0]                    swap_limit;
  logic [23:0]                   chirp_dwell;
  logic [msctg_pkg::QHZ_W-1:0]   chirp_limit;

  // test state
  logic                          running;
  logic [msctg_pkg::TIME_W-1:0]  segment_start;
  logic [msctg_pkg::TIME_W-1:0]  toggle_start;
  logic [7:0]                    swap_count;
  logic [msctg_pkg::QHZ_W-1:0]   chirp_qhz;
  logic [msctg_pkg::HALF_W-1:0]  half_period;
  logic [msctg_pkg::LEVEL_W-1:0] level_old;
  logic [msctg_pkg::LEVEL_W-1:0] level_new;
  logic [msctg_pkg::TIME_W-1:0]  now_q;
  logic                          issue;
  logic                          div_start;

  logic                          s_accept;
  logic                          sel_valid;
  logic                          cmp_start;
  logic [msctg_pkg::LEVEL_W-1:0] cfg_level;
  logic                          cfg_sel_ok;
  logic [7:0]                    swap_inc;
  logic [msctg_pkg::QHZ_W:0]     chirp_next;
  func_t                         func_in;

  msctg_pkg::cmp_status_t cmp_seg;
  msctg_pkg::cmp_status_t cmp_tog;
  msctg_pkg::div_status_t div_st;

  always_comb begin
    s_tready   = (state == S_IDLE);
    s_accept   = s_tvalid && s_tready;
    func_in    = func_t'(s_tuser);
    sel_valid  = (act_sel != SEL_NONE);
    cmp_start  = s_accept && (func_in == FUNC_TICK) && running && sel_valid;
    cfg_level  = (cfg_data[msctg_pkg::LEVEL_W-1:0] > msctg_pkg::LEVEL_MAX) ?
                 msctg_pkg::LEVEL_MAX : cfg_data[msctg_pkg::LEVEL_W-1:0];
    cfg_sel_ok = !cfg_data[3] && (int'(cfg_data[2:0]) < msctg_pkg::NUM_ACTUATORS);
    swap_inc   = swap_count + 8'd1;
    chirp_next = {1'b0, chirp_qhz} + 1'b1;
  end

  msctg_serial_cmp u_cmp_seg (
    .clk    (clk),
    .rst    (rst),
    .start  (cmp_start),
    .a      (s_tdata),
    .b      (segment_start),
    .c      (test_mode ? {8'd0, chirp_dwell} : {8'd0, step_period}),
    .status (cmp_seg)
  );

  msctg_serial_cmp u_cmp_tog (
    .clk    (clk),
    .rst    (rst),
    .start  (cmp_start),
    .a      (s_tdata),
    .b      (toggle_start),
    .c      ({(msctg_pkg::TIME_W - msctg_pkg::HALF_W)'(0), half_period}),
    .status (cmp_tog)
  );

  msctg_serial_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (chirp_qhz),
    .status  (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      level_low     <= msctg_pkg::LEVEL_W'(1000);
      level_high    <= msctg_pkg::LEVEL_W'(9600);
      act_sel       <= SEL_NONE;
      test_mode     <= 1'b0;
      step_period   <= 24'd1000000;
      swap_limit    <= 8'd20;
      chirp_dwell   <= 24'd2000000;
      chirp_limit   <= msctg_pkg::QHZ_W'(60);
      running       <= 1'b0;
      segment_start <= '0;
      toggle_start  <= '0;
      swap_count    <= '0;
      chirp_qhz     <= msctg_pkg::QHZ_W'(1);
      half_period   <= msctg_pkg::HALF_PERIOD_NUM;
      level_old     <= msctg_pkg::LEVEL_W'(1000);
      level_new     <= msctg_pkg::LEVEL_W'(9600);
      issue         <= 1'b0;
      div_start     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // frequency step that stays within the limit needs a new half period
      div_start <= (state == S_CMP) && cmp_seg.done && test_mode && cmp_seg.gt &&
                   (chirp_next <= {1'b0, chirp_limit});
      if (m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_wr_en) begin
        unique case (reg_idx_t'(cfg_index))
          REG_LEVEL_LOW: begin
            if (!running) begin
              level_low <= cfg_level;
              level_old <= cfg_level;
              level_new <= level_high;
            end
          end
          REG_LEVEL_HIGH: begin
            if (!running) begin
              level_high <= cfg_level;
              level_old  <= level_low;
              level_new  <= cfg_level;
            end
          end
          REG_ACT_SEL: begin
            if (!running) begin
              act_sel <= cfg_sel_ok ? cfg_data[3:0] : SEL_NONE;
            end
          end
          REG_TEST_MODE: begin
            if (!running) begin
              test_mode <= cfg_data[0];
            end
          end
          REG_STEP_PERIOD: step_period <= cfg_data;
          REG_SWAP_LIMIT:  swap_limit  <= cfg_data[7:0];
          REG_CHIRP_DWELL: chirp_dwell <= cfg_data;
          REG_CHIRP_LIMIT: chirp_limit <= cfg_data[msctg_pkg::QHZ_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            now_q <= s_tdata;
            issue <= 1'b0;
            state <= cmp_start ? S_CMP : S_OUT;
            case (func_in)
              FUNC_START: begin
                if (sel_valid && !running) begin
                  segment_start <= s_tdata;
                  toggle_start  <= s_tdata;
                  running       <= 1'b1;
                end
              end
              FUNC_STOP: begin
                if (sel_valid) begin
                  swap_count  <= '0;
                  chirp_qhz   <= msctg_pkg::QHZ_W'(1);
                  half_period <= msctg_pkg::HALF_PERIOD_NUM;
                  running     <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_CMP: begin
          if (cmp_seg.done) begin
            if (!test_mode) begin
              issue <= 1'b1;
              state <= S_OUT;
              if (cmp_seg.gt) begin
                segment_start <= now_q;
                level_old     <= level_new;
                level_new     <= level_old;
                if (swap_inc >= swap_limit) begin
                  swap_count  <= '0;
                  chirp_qhz   <= msctg_pkg::QHZ_W'(1);
                  half_period <= msctg_pkg::HALF_PERIOD_NUM;
                  running     <= 1'b0;
                end else begin
                  swap_count  <= swap_inc;
                end
              end
            end else if (cmp_seg.gt) begin
              segment_start <= now_q;
              toggle_start  <= now_q;
              if (chirp_next > {1'b0, chirp_limit}) begin
                swap_count  <= '0;
                chirp_qhz   <= msctg_pkg::QHZ_W'(1);
                half_period <= msctg_pkg::HALF_PERIOD_NUM;
                running     <= 1'b0;
                issue       <= 1'b0;
                state       <= S_OUT;
              end else begin
                issue     <= 1'b1;
                chirp_qhz <= chirp_next[msctg_pkg::QHZ_W-1:0];
                state     <= S_DIV;
              end
            end else begin
              issue <= 1'b1;
              state <= S_OUT;
              if (cmp_tog.gt) begin
                toggle_start <= now_q;
                level_old    <= level_new;
                level_new    <= level_old;
              end
            end
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            half_period <= div_st.quotient;
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= issue;
            m_tdata  <= {6'd0, running,
                         issue ? level_new : {msctg_pkg::LEVEL_W{1'b0}},
                         issue ? act_sel[2:0] : 3'd0};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cmp_done_in_cmp: assert property (@(posedge clk) disable iff (rst)
    cmp_seg.done |-> (state == S_CMP))
    else $error("compare finished outside the compare phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DIV))
    else $error("divide finished outside the divide phase");

  a_running_has_sel: assert property (@(posedge clk) disable iff (rst)
    running |-> sel_valid)
    else $error("test running with no actuator selected");

  a_chirp_nonzero: assert property (@(posedge clk) disable iff (rst)
    chirp_qhz != '0)
    else $error("chirp frequency reached zero");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (level_old <= msctg_pkg::LEVEL_MAX) && (level_new <= msctg_pkg::LEVEL_MAX))
    else $error("drive level above maximum");
`endif

endmodule

// ===== tb/motor_step_chirp_test_generator_top_tb.sv =====
// ----------------------------------------------------------------------------
// motor_step_chirp_test_generator_top_tb
// self-checking bench for the step / chirp drive-level test generator
// ----------------------------------------------------------------------------
// timestamped ticks and start/stop commands go in on the slave stream, and a
// behavioural model of the generator (levels, swap counting, chirp frequency
// steps, half-period toggling) predicts the drive command of every
// transaction. results on the master stream are checked field by field in
// order. directed cases come first, then a full chirp sweep, randomised
// settings phases, most with random idling on both sides, and a long receiver
// hold-off that fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_step_chirp_test_generator_top_tb;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_START = 2'd1,
    FN_STOP  = 2'd2,
    FN_SPARE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_LEVEL_LOW   = 3'd0,
    REG_LEVEL_HIGH  = 3'd1,
    REG_ACTUATOR    = 3'd2,
    REG_MODE        = 3'd3,
    REG_STEP_PERIOD = 3'd4,
    REG_SWAP_LIMIT  = 3'd5,
    REG_CHIRP_DWELL = 3'd6,
    REG_CHIRP_LIMIT = 3'd7
  } reg_t;

  localparam logic MODE_STEP  = 1'b0;
  localparam logic MODE_CHIRP = 1'b1;
  localparam int   NO_ACTUATOR = -1;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int IDLE_PCT      = 21;

  typedef struct packed {
    logic                          issued;
    logic [2:0]                    actuator;
    logic [msctg_pkg::LEVEL_W-1:0] level;
    logic                          running;
  } drive_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  motor_step_chirp_test_generator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // generator model: settings
  logic [msctg_pkg::LEVEL_W-1:0] cfg_level_low, cfg_level_high;
  int                            cfg_actuator;
  logic                          cfg_mode;
  logic [23:0]                   cfg_step_period, cfg_dwell;
  logic [7:0]                    cfg_swap_limit;
  logic [msctg_pkg::QHZ_W-1:0]   cfg_chirp_limit;

  // generator model: test state
  logic                          st_running;
  logic [msctg_pkg::TIME_W-1:0]  st_seg_start, st_tog_start;
  logic [7:0]                    st_swaps;
  logic [msctg_pkg::QHZ_W-1:0]   st_qhz;
  logic [msctg_pkg::HALF_W-1:0]  st_half_us;
  logic [msctg_pkg::LEVEL_W-1:0] st_level_old, st_level_new;

  drive_cmd_t  pending_drive_cmds[$];
  int          error_count = 0;
  int          result_count = 0;
  int          cycle_count = 0;
  int          sink_hold = 0;
  bit          src_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  logic [31:0] last_now = '0;

  function automatic logic [msctg_pkg::HALF_W-1:0] half_period_of(
      logic [msctg_pkg::QHZ_W-1:0] qhz);
    return (qhz == '0) ? msctg_pkg::HALF_PERIOD_NUM : msctg_pkg::HALF_PERIOD_NUM / qhz;
  endfunction

  function automatic void stop_run();
    st_swaps   = '0;
    st_qhz     = msctg_pkg::QHZ_W'(1);
    st_half_us = half_period_of(msctg_pkg::QHZ_W'(1));
    st_running = 1'b0;
  endfunction

  function automatic void swap_level_pair();
    logic [msctg_pkg::LEVEL_W-1:0] held;
    held         = st_level_old;
    st_level_old = st_level_new;
    st_level_new = held;
  endfunction

  function automatic void model_reset();
    cfg_level_low   = msctg_pkg::LEVEL_W'(1000);
    cfg_level_high  = msctg_pkg::LEVEL_MAX;
    cfg_actuator    = NO_ACTUATOR;
    cfg_mode        = MODE_STEP;
    cfg_step_period = 24'd1000000;
    cfg_swap_limit  = 8'd20;
    cfg_dwell       = 24'd2000000;
    cfg_chirp_limit = msctg_pkg::QHZ_W'(60);
    st_seg_start    = '0;
    st_tog_start    = '0;
    stop_run();
    st_level_old    = cfg_level_low;
    st_level_new    = cfg_level_high;
  endfunction

  function automatic void model_config(reg_t idx, logic [23:0] data);
    logic [msctg_pkg::LEVEL_W-1:0] lv;
    int sel;
    lv  = data[msctg_pkg::LEVEL_W-1:0];
    sel = int'($signed(data[3:0]));
    case (idx)
      REG_LEVEL_LOW, REG_LEVEL_HIGH: begin
        if (!st_running) begin
          if (lv > msctg_pkg::LEVEL_MAX) lv = msctg_pkg::LEVEL_MAX;
          if (idx == REG_LEVEL_LOW) cfg_level_low = lv;
          else cfg_level_high = lv;
          st_level_old = cfg_level_low;
          st_level_new = cfg_level_high;
        end
      end
      REG_ACTUATOR: begin
        if (!st_running)
          cfg_actuator = (sel >= 0 && sel < msctg_pkg::NUM_ACTUATORS) ? sel : NO_ACTUATOR;
      end
      REG_MODE: begin
        if (!st_running) cfg_mode = data[0];
      end
      REG_STEP_PERIOD: cfg_step_period = data;
      REG_SWAP_LIMIT:  cfg_swap_limit  = data[7:0];
      REG_CHIRP_DWELL: cfg_dwell       = data;
      REG_CHIRP_LIMIT: cfg_chirp_limit = data[msctg_pkg::QHZ_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic drive_cmd_t predict_drive(func_t fn, logic [31:0] now);
    drive_cmd_t  cmd;
    logic        issue;
    logic [31:0] seg_elapsed, tog_elapsed;
    logic [7:0]  next_qhz;
    issue       = 1'b0;
    seg_elapsed = now - st_seg_start;
    tog_elapsed = now - st_tog_start;
    if (fn == FN_START || fn == FN_STOP) begin
      if (cfg_actuator != NO_ACTUATOR) begin
        if (fn == FN_STOP) begin
          stop_run();
        end else if (!st_running) begin
          st_seg_start = now;
          st_tog_start = now;
          st_running   = 1'b1;
        end
      end
    end else if (fn == FN_TICK && st_running && cfg_actuator != NO_ACTUATOR) begin
      issue = 1'b1;
      if (cfg_mode == MODE_STEP) begin
        if (seg_elapsed > 32'(cfg_step_period)) begin
          st_seg_start = now;
          swap_level_pair();
          st_swaps = st_swaps + 8'd1;
          if (st_swaps >= cfg_swap_limit) stop_run();
        end
      end else begin
        if (seg_elapsed > 32'(cfg_dwell)) begin
          next_qhz     = 8'(st_qhz) + 8'd1;
          st_seg_start = now;
          st_tog_start = now;
          if (next_qhz > 8'(cfg_chirp_limit)) begin
            stop_run();
            issue = 1'b0;
          end else begin
            st_qhz     = next_qhz[msctg_pkg::QHZ_W-1:0];
            st_half_us = half_period_of(st_qhz);
          end
        end else if (tog_elapsed > 32'(st_half_us)) begin
          st_tog_start = now;
          swap_level_pair();
        end
      end
    end
    cmd.issued   = issue;
    cmd.actuator = issue ? cfg_actuator[2:0] : 3'd0;
    cmd.level    = issue ? st_level_new : '0;
    cmd.running  = st_running;
    return cmd;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
             result_count, field, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    drive_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_drive_cmds.size() == 0) begin
        report_mismatch("unexpected transaction", {8'd0, m_tdata}, 32'd0);
      end else begin
        want = pending_drive_cmds.pop_front();
        if (m_tuser !== want.issued)
          report_mismatch("drive_valid", 32'(m_tuser), 32'(want.issued));
        if (m_tdata[2:0] !== want.actuator)
          report_mismatch("target_actuator", 32'(m_tdata[2:0]), 32'(want.actuator));
        if (m_tdata[16:3] !== want.level)
          report_mismatch("drive_level", 32'(m_tdata[16:3]), 32'(want.level));
        if (m_tdata[17] !== want.running)
          report_mismatch("test_running", 32'(m_tdata[17]), 32'(want.running));
        if (m_tdata[23:18] !== 6'd0)
          report_mismatch("tdata padding", 32'(m_tdata[23:18]), 32'd0);
      end
      result_count++;
    end
  end

  // receiver readiness, with a counted hold-off
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_tready  <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_tready <= !(sink_gaps && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_drive_cmds.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(func_t fn, logic [31:0] now);
    @(negedge clk);
    while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= now;
    do @(posedge clk); while (!s_tready);
    pending_drive_cmds.push_back(predict_drive(fn, now));
    last_now = now;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_drive_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_t idx, logic [23:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    model_config(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [23:0] pick_setting(logic [23:0] top, logic [23:0] common_hi);
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'd1;
      2: return top;
      3: return 24'($urandom);
      default: return 24'($urandom_range(1, common_hi));
    endcase
  endfunction

  function automatic logic [23:0] pick_level();
    case ($urandom_range(7))
      0: return 24'd0;
      1: return 24'(msctg_pkg::LEVEL_MAX);
      2: return 24'($urandom_range(9601, 16383));
      3: return 24'($urandom);
      default: return 24'($urandom_range(0, 9600));
    endcase
  endfunction

  task automatic randomise_settings();
    write_reg(REG_LEVEL_LOW, pick_level());
    write_reg(REG_LEVEL_HIGH, pick_level());
    write_reg(REG_ACTUATOR, ($urandom_range(9) < 8) ? 24'($urandom_range(0, 7)) : 24'($urandom));
    write_reg(REG_MODE, ($urandom_range(5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1)));
    write_reg(REG_STEP_PERIOD, pick_setting(24'hFFFFFF, 24'd40));
    write_reg(REG_SWAP_LIMIT, pick_setting(24'd255, 24'd12));
    write_reg(REG_CHIRP_DWELL, pick_setting(24'hFFFFFF, 24'd3000000));
    write_reg(REG_CHIRP_LIMIT, pick_setting(24'd127, 24'd8));
  endtask

  // a tick timed against whichever boundary the running test is heading for
  task automatic send_timed_tick();
    logic [31:0] thr, base, now;
    bit use_half;
    use_half = (cfg_mode == MODE_CHIRP) && $urandom_range(1);
    thr  = (cfg_mode == MODE_STEP) ? 32'(cfg_step_period) :
           use_half ? 32'(st_half_us) : 32'(cfg_dwell);
    base = use_half ? st_tog_start : st_seg_start;
    case ($urandom_range(7))
      0, 1:    now = last_now + 32'($urandom_range(0, 3));
      2, 3, 4: now = base + thr + 32'($urandom_range(0, 2)) - 32'd1;
      5, 6:    now = last_now + 32'($urandom_range(0, thr));
      default: now = $urandom;
    endcase
    send_item(FN_TICK, now);
  endtask

  task automatic run_random_phase(int n_items);
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_item(func_t'($urandom_range(3)), $urandom);
      end else if (!st_running) begin
        send_item(FN_START, (r < 20) ? 32'hFFFFFFFF - 32'($urandom_range(0, 200))
                                    : last_now + 32'($urandom_range(0, 50)));
      end else if (r < 13) begin
        send_item(FN_STOP, last_now + 32'($urandom_range(0, 9)));
      end else begin
        send_timed_tick();
      end
    end
    if ($urandom_range(9) < 7) send_item(FN_STOP, last_now);
  endtask

  task automatic test_idle_ignores();
    send_item(FN_TICK, 32'd0);
    send_item(FN_START, 32'd5);
    send_item(FN_STOP, 32'hFFFFFFFF);
    send_item(FN_SPARE, 32'hFFFFFFFF);
    send_item(FN_TICK, 32'h80000000);
    wait_drain();
  endtask

  task automatic test_step_directed();
    logic [31:0] t0;
    t0 = 32'hFFFFFFF0;
    write_reg(REG_LEVEL_LOW, 24'd16383);
    write_reg(REG_LEVEL_HIGH, 24'd0);
    write_reg(REG_ACTUATOR, 24'd7);
    write_reg(REG_MODE, 24'(MODE_STEP));
    write_reg(REG_STEP_PERIOD, 24'd4);
    write_reg(REG_SWAP_LIMIT, 24'd3);
    send_item(FN_START, t0);
    send_item(FN_TICK, t0 + 32'd4);
    send_item(FN_TICK, t0 + 32'd5);
    send_item(FN_START, t0 + 32'd6);
    send_item(FN_TICK, t0 + 32'd9);
    send_item(FN_TICK, t0 + 32'd16);
    send_item(FN_TICK, t0 + 32'd100);
    send_item(FN_TICK, t0 + 32'd200);
    send_item(FN_START, 32'd500);
    wait_drain();
    // level, actuator and mode writes are dropped while the test runs
    write_reg(REG_LEVEL_LOW, 24'd0);
    write_reg(REG_ACTUATOR, 24'd8);
    write_reg(REG_MODE, 24'(MODE_CHIRP));
    send_item(FN_TICK, 32'd510);
    send_item(FN_STOP, 32'd530);
    wait_drain();
  endtask

  task automatic test_chirp_directed();
    logic [31:0] t0;
    t0 = 32'd100;
    write_reg(REG_MODE, 24'(MODE_CHIRP));
    write_reg(REG_ACTUATOR, 24'd0);
    write_reg(REG_LEVEL_LOW, 24'd0);
    write_reg(REG_LEVEL_HIGH, 24'(msctg_pkg::LEVEL_MAX));
    write_reg(REG_CHIRP_DWELL, 24'hFFFFFF);
    write_reg(REG_CHIRP_LIMIT, 24'd2);
    send_item(FN_START, t0);
    send_item(FN_TICK, t0 + 32'd2000000);
    send_item(FN_TICK, t0 + 32'd2000001);
    send_item(FN_TICK, t0 + 32'd16777216);
    send_item(FN_TICK, t0 + 32'd16777216 + 32'd1000001);
    send_item(FN_TICK, t0 + 32'd33554432);
    send_item(FN_STOP, t0 + 32'd33554433);
    wait_drain();
  endtask

  // every tick of the running test is a frequency step, right up to the top of the range
  task automatic test_chirp_sweep();
    write_reg(REG_CHIRP_DWELL, 24'd0);
    write_reg(REG_CHIRP_LIMIT, 24'd127);
    send_item(FN_START, 32'd1000);
    for (int i = 1; i <= 130; i++) send_item(FN_TICK, 32'd1000 + 32'(i));
    wait_drain();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 17; p++) begin
      src_gaps  = !(p >= 5 && p <= 7);
      sink_gaps = src_gaps;
      randomise_settings();
      run_random_phase(22);
      wait_drain();
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    write_reg(REG_MODE, 24'(MODE_STEP));
    write_reg(REG_ACTUATOR, 24'd3);
    write_reg(REG_STEP_PERIOD, 24'd10);
    write_reg(REG_SWAP_LIMIT, 24'd255);
    send_item(FN_START, 32'd0);
    wait_drain();
    sink_hold = 300;
    for (int i = 1; i <= 12; i++) send_item(FN_TICK, 32'(i * 7));
    send_item(FN_STOP, 32'd100);
    wait_drain();
  endtask

  initial begin
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_ignores();
    test_step_directed();
    test_chirp_directed();
    test_chirp_sweep();
    test_random_phases();
    test_backpressure();
    wait_drain();
    if (error_count == 0 && pending_drive_cmds.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/msctg_pkg.sv
rtl/msctg_serial_cmp.sv
rtl/msctg_serial_div.sv
rtl/motor_step_chirp_test_generator_top.sv
tb/motor_step_chirp_test_generator_top_tb.sv
